FILE: rtl/core/sit_pkg.sv
// Shared types, constants and helpers for the stream id table.
`timescale 1ns / 1ps

package sit_pkg;

  // Table geometry
  localparam int TABLE_SLOTS = 8;
  localparam int IDX_W       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

  // Field widths
  localparam int PT_W   = 7;
  localparam int ID_W   = 32;
  localparam int TIME_W = 48;
  localparam int TO_W   = 32;

  // Configuration port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam logic [TO_W-1:0] TIMEOUT_RESET = TO_W'(30 * 1000);

  // Register indexes
  localparam logic [1:0] REG_SCREEN  = 2'd0;
  localparam logic [1:0] REG_CAMERA  = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_IGNORED   = 2'd0;
  localparam logic [1:0] ST_HIT       = 2'd1;
  localparam logic [1:0] ST_NEW       = 2'd2;
  localparam logic [1:0] ST_NO_STREAM = 2'd3;

  // Shared compare unit operations
  typedef enum logic [1:0] {
    OP_KEY_EQ = 2'd0,
    OP_IDLE   = 2'd1,
    OP_OLDER  = 2'd2
  } cmp_op_e;

  typedef struct packed {
    logic [PT_W-1:0]   payload_type;
    logic [ID_W-1:0]   packet_source;
    logic [ID_W-1:0]   pinned_source;
    logic [TIME_W-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [ID_W-1:0] stream_id;
    logic [2:0]      slot;
    logic [3:0]      removed_count;
  } out_item_t;

  typedef struct packed {
    logic [PT_W-1:0] screen_pt;
    logic [PT_W-1:0] camera_pt;
    logic [TO_W-1:0] timeout;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [ID_W-1:0]   key;
    logic [TIME_W-1:0] last_seen;
  } tbl_rd_t;

  typedef struct packed {
    logic              set_valid;
    logic              clr_valid;
    logic              wr_key;
    logic              wr_time;
    logic [IDX_W-1:0]  idx;
    logic [ID_W-1:0]   key;
    logic [TIME_W-1:0] last_seen;
  } tbl_wr_t;

  typedef struct packed {
    cmp_op_e           op;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] now_ms;
    logic [TIME_W-1:0] best_ls;
  } cmp_req_t;

  typedef struct packed {
    logic eq;
    logic lt;
    logic idle;
  } cmp_res_t;

  // Slot index masked to the three bits of the result field
  localparam int SLOT_X_W = (IDX_W > 3) ? IDX_W : 3;
  function automatic logic [2:0] slot_field(input logic [IDX_W-1:0] idx);
    logic [SLOT_X_W-1:0] ext;
    ext = SLOT_X_W'(idx);
    return ext[2:0];
  endfunction

  // Removal count saturated to the four bits of the result field
  localparam int CNT_X_W = (CNT_W > 4) ? CNT_W : 4;
  function automatic logic [3:0] removed_field(input logic [CNT_W-1:0] cnt);
    logic [CNT_X_W-1:0] ext;
    ext = CNT_X_W'(cnt);
    return (ext > CNT_X_W'(15)) ? 4'hF : ext[3:0];
  endfunction

endpackage

FILE: rtl/core/stream_id_table_with_idle_eviction.sv
// Top level of the stream id table with idle eviction.
//
//   channel   direction  handshake              beat
//   in        sink       in_valid_i/in_stall_o  sit_pkg::in_item_t
//   out       source     out_valid_o/out_stall_i sit_pkg::out_item_t
//   config    slave      psel/penable/pready    3 x 32-bit registers
//
// One packet is processed at a time. The slot walk shares a single 49-bit
// compare unit, one slot per cycle: ignored and zero-id packets skip the walk,
// a hit ends it at the matching slot, a miss walks the table for lookup and
// prune, and a miss on a full table with nothing pruned walks it once more.
// Reset clears the valid flags at once; there is no clearing pass.
// The input is taken again as soon as a result sits in the output register;
// a stalled output holds the sequencer in its final step.
`timescale 1ns / 1ps

module stream_id_table_with_idle_eviction (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  sit_pkg::in_item_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output sit_pkg::out_item_t          out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sit_pkg::PADDR_W-1:0] paddr,
  input  logic [sit_pkg::PDATA_W-1:0] pwdata,
  output logic [sit_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  sit_pkg::cfg_t             cfg;
  logic [sit_pkg::IDX_W-1:0] rd_idx;
  sit_pkg::tbl_rd_t          rd;
  sit_pkg::tbl_wr_t          wr;
  sit_pkg::cmp_req_t         cmp_req;
  sit_pkg::cmp_res_t         cmp_res;

  sit_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sit_table u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_idx_i (rd_idx),
    .rd_o     (rd),
    .wr_i     (wr)
  );

  sit_cmp u_cmp (
    .req_i     (cmp_req),
    .rd_i      (rd),
    .timeout_i (cfg.timeout),
    .res_o     (cmp_res)
  );

  sit_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_i       (cfg),
    .rd_idx_o    (rd_idx),
    .rd_i        (rd),
    .wr_o        (wr),
    .cmp_req_o   (cmp_req),
    .cmp_res_i   (cmp_res)
  );

endmodule

FILE: rtl/core/sit_regs.sv
// Configuration registers behind the APB-style port.
`timescale 1ns / 1ps

module sit_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [sit_pkg::PADDR_W-1:0] paddr,
  input  logic [sit_pkg::PDATA_W-1:0] pwdata,
  output logic [sit_pkg::PDATA_W-1:0] prdata,
  output logic                      pready,
  output sit_pkg::cfg_t             cfg_o
);

  sit_pkg::cfg_t cfg_q, cfg_d;
  logic          wr_en;
  logic [1:0]    reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  // Decode the write beat
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        sit_pkg::REG_SCREEN:  cfg_d.screen_pt = pwdata[sit_pkg::PT_W-1:0];
        sit_pkg::REG_CAMERA:  cfg_d.camera_pt = pwdata[sit_pkg::PT_W-1:0];
        sit_pkg::REG_TIMEOUT: cfg_d.timeout   = pwdata[sit_pkg::TO_W-1:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_pt <= '0;
      cfg_q.camera_pt <= '0;
      cfg_q.timeout   <= sit_pkg::TIMEOUT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      sit_pkg::REG_SCREEN:  prdata = sit_pkg::PDATA_W'(cfg_q.screen_pt);
      sit_pkg::REG_CAMERA:  prdata = sit_pkg::PDATA_W'(cfg_q.camera_pt);
      sit_pkg::REG_TIMEOUT: prdata = sit_pkg::PDATA_W'(cfg_q.timeout);
      default:              prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/core/sit_table.sv
// Slot storage: valid flags, keys and last-seen times with one read and one write port.
`timescale 1ns / 1ps

module sit_table (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [sit_pkg::IDX_W-1:0]   rd_idx_i,
  output sit_pkg::tbl_rd_t            rd_o,
  input  sit_pkg::tbl_wr_t            wr_i
);

  logic [sit_pkg::TABLE_SLOTS-1:0] valid_q, valid_d;
  logic [sit_pkg::ID_W-1:0]        key_q  [sit_pkg::TABLE_SLOTS];
  logic [sit_pkg::TIME_W-1:0]      time_q [sit_pkg::TABLE_SLOTS];

  // Update valid flags
  always_comb begin
    valid_d = valid_q;
    if (wr_i.clr_valid) valid_d[wr_i.idx] = 1'b0;
    if (wr_i.set_valid) valid_d[wr_i.idx] = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Write payload entries
  always_ff @(posedge clk_i) begin
    if (wr_i.wr_key)  key_q[wr_i.idx]  <= wr_i.key;
    if (wr_i.wr_time) time_q[wr_i.idx] <= wr_i.last_seen;
  end

  assign rd_o.valid     = valid_q[rd_idx_i];
  assign rd_o.key       = key_q[rd_idx_i];
  assign rd_o.last_seen = time_q[rd_idx_i];

endmodule

FILE: rtl/core/sit_cmp.sv
// Shared compare unit: one 49-bit subtractor serving key match, idle test and age order.
`timescale 1ns / 1ps

module sit_cmp (
  input  sit_pkg::cmp_req_t         req_i,
  input  sit_pkg::tbl_rd_t          rd_i,
  input  logic [sit_pkg::TO_W-1:0]  timeout_i,
  output sit_pkg::cmp_res_t         res_o
);

  logic [sit_pkg::TIME_W-1:0] op_a, op_b;
  logic [sit_pkg::TIME_W:0]   diff;

  // Select operands
  always_comb begin
    case (req_i.op)
      sit_pkg::OP_KEY_EQ: begin
        op_a = sit_pkg::TIME_W'(rd_i.key);
        op_b = sit_pkg::TIME_W'(req_i.id);
      end
      sit_pkg::OP_IDLE: begin
        op_a = req_i.now_ms;
        op_b = rd_i.last_seen;
      end
      sit_pkg::OP_OLDER: begin
        op_a = rd_i.last_seen;
        op_b = req_i.best_ls;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign diff = {1'b0, op_a} - {1'b0, op_b};

  // Borrow means a < b; idle needs no borrow and an age beyond the timeout
  assign res_o.eq   = (diff == '0);
  assign res_o.lt   = diff[sit_pkg::TIME_W];
  assign res_o.idle = !diff[sit_pkg::TIME_W] &&
                      (diff[sit_pkg::TIME_W-1:0] > sit_pkg::TIME_W'(timeout_i));

endmodule

FILE: rtl/core/sit_ctrl.sv
// Sequencer: screening, lookup, prune, oldest search and insert, plus the result register.
`timescale 1ns / 1ps

module sit_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  sit_pkg::in_item_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output sit_pkg::out_item_t          out_data_o,
  input  sit_pkg::cfg_t               cfg_i,
  output logic [sit_pkg::IDX_W-1:0]   rd_idx_o,
  input  sit_pkg::tbl_rd_t            rd_i,
  output sit_pkg::tbl_wr_t            wr_o,
  output sit_pkg::cmp_req_t           cmp_req_o,
  input  sit_pkg::cmp_res_t           cmp_res_i
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_HIT    = 3'd2;
  localparam logic [2:0] S_PRUNE  = 3'd3;
  localparam logic [2:0] S_OLDEST = 3'd4;
  localparam logic [2:0] S_INSERT = 3'd5;
  localparam logic [2:0] S_RESP   = 3'd6;

  logic [2:0]                  state_q, state_d;
  logic [sit_pkg::IDX_W-1:0]   idx_q, idx_d;
  sit_pkg::in_item_t           item_q, item_d;
  logic [sit_pkg::ID_W-1:0]    id_q, id_d;
  logic [sit_pkg::CNT_W-1:0]   removed_q, removed_d;
  logic                        free_found_q, free_found_d;
  logic [sit_pkg::IDX_W-1:0]   free_idx_q, free_idx_d;
  logic [sit_pkg::IDX_W-1:0]   best_idx_q, best_idx_d;
  logic [sit_pkg::TIME_W-1:0]  best_ls_q, best_ls_d;
  sit_pkg::out_item_t          res_q, res_d;
  logic                        out_valid_q, out_valid_d;
  sit_pkg::out_item_t          out_q, out_d;

  logic                        pinned;
  logic                        ignore;
  logic [sit_pkg::ID_W-1:0]    id_sel;
  logic                        last;
  logic                        drop;
  logic                        free_now;
  logic                        take;
  logic [sit_pkg::IDX_W-1:0]   best_sel;
  logic                        load_out;

  assign pinned   = (item_q.pinned_source != '0);
  assign ignore   = ((item_q.payload_type != cfg_i.screen_pt) &&
                     (item_q.payload_type != cfg_i.camera_pt)) ||
                    (pinned && (item_q.packet_source != item_q.pinned_source));
  assign id_sel   = pinned ? item_q.pinned_source : item_q.packet_source;
  assign last     = (idx_q == sit_pkg::LAST_IDX);
  assign rd_idx_o = idx_q;

  // Drive the shared unit
  always_comb begin
    cmp_req_o.id      = id_q;
    cmp_req_o.now_ms  = item_q.now_ms;
    cmp_req_o.best_ls = best_ls_q;
    case (state_q)
      S_PRUNE:  cmp_req_o.op = pinned ? sit_pkg::OP_KEY_EQ : sit_pkg::OP_IDLE;
      S_OLDEST: cmp_req_o.op = sit_pkg::OP_OLDER;
      default:  cmp_req_o.op = sit_pkg::OP_KEY_EQ;
    endcase
  end

  // Per-slot decisions
  assign drop     = rd_i.valid && (pinned ? !cmp_res_i.eq : cmp_res_i.idle);
  assign free_now = !rd_i.valid || drop;
  assign take     = (idx_q == '0) || cmp_res_i.lt;
  assign best_sel = take ? idx_q : best_idx_q;
  assign load_out = !out_valid_q || !out_stall_i;

  // Sequencer
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    item_d       = item_q;
    id_d         = id_q;
    removed_d    = removed_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    best_idx_d   = best_idx_q;
    best_ls_d    = best_ls_q;
    res_d        = res_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    wr_o         = '0;
    wr_o.idx     = idx_q;
    wr_o.key     = id_q;
    wr_o.last_seen = item_q.now_ms;

    // Retire a taken beat
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        id_d  = id_sel;
        idx_d = '0;
        if (ignore) begin
          res_d   = '{status: sit_pkg::ST_IGNORED, default: '0};
          state_d = S_RESP;
        end else if (id_sel == '0) begin
          res_d   = '{status: sit_pkg::ST_NO_STREAM, default: '0};
          state_d = S_RESP;
        end else begin
          state_d = S_HIT;
        end
      end
      S_HIT: begin
        if (rd_i.valid && cmp_res_i.eq) begin
          // Refresh last-seen of the matching slot
          wr_o.wr_time        = 1'b1;
          res_d.status        = sit_pkg::ST_HIT;
          res_d.stream_id     = id_q;
          res_d.slot          = sit_pkg::slot_field(idx_q);
          res_d.removed_count = '0;
          state_d             = S_RESP;
        end else if (last) begin
          idx_d        = '0;
          removed_d    = '0;
          free_found_d = 1'b0;
          state_d      = S_PRUNE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_PRUNE: begin
        if (drop) begin
          wr_o.clr_valid = 1'b1;
          removed_d      = removed_q + 1'b1;
        end
        if (free_now && !free_found_q) begin
          free_found_d = 1'b1;
          free_idx_d   = idx_q;
        end
        if (last) begin
          idx_d   = '0;
          state_d = (free_found_q || free_now) ? S_INSERT : S_OLDEST;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_OLDEST: begin
        if (last) begin
          // Evict the oldest, lowest slot on ties
          wr_o.clr_valid = 1'b1;
          wr_o.idx       = best_sel;
          removed_d      = removed_q + 1'b1;
          free_idx_d     = best_sel;
          idx_d          = '0;
          state_d        = S_INSERT;
        end else begin
          if (take) begin
            best_idx_d = idx_q;
            best_ls_d  = rd_i.last_seen;
          end
          idx_d = idx_q + 1'b1;
        end
      end
      S_INSERT: begin
        wr_o.idx            = free_idx_q;
        wr_o.set_valid      = 1'b1;
        wr_o.wr_key         = 1'b1;
        wr_o.wr_time        = 1'b1;
        res_d.status        = sit_pkg::ST_NEW;
        res_d.stream_id     = id_q;
        res_d.slot          = sit_pkg::slot_field(free_idx_q);
        res_d.removed_count = sit_pkg::removed_field(removed_q);
        state_d             = S_RESP;
      end
      S_RESP: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    item_q       <= item_d;
    id_q         <= id_d;
    removed_q    <= removed_d;
    free_found_q <= free_found_d;
    free_idx_q   <= free_idx_d;
    best_idx_q   <= best_idx_d;
    best_ls_q    <= best_ls_d;
    res_q        <= res_d;
    out_q        <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/core/sit_checker.sv
// Port-level checks for the stream id table, bound to the top level.
`timescale 1ns / 1ps

module sit_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input sit_pkg::out_item_t out_data_o
);

  // One packet in flight: an accepted beat stalls the input next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while a packet is in flight");

  // Ignored and zero-id results carry no id, slot or removals
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_data_o.status == sit_pkg::ST_IGNORED) ||
                    (out_data_o.status == sit_pkg::ST_NO_STREAM)) |->
    (out_data_o.stream_id == '0) && (out_data_o.slot == '0) &&
    (out_data_o.removed_count == '0))
    else $error("ignored or no-stream result has nonzero fields");

  // A hit removes nothing and names a real stream
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == sit_pkg::ST_HIT) |->
    (out_data_o.removed_count == '0) && (out_data_o.stream_id != '0))
    else $error("hit result with removals or zero id");

  // A new entry names a real stream
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == sit_pkg::ST_NEW) |->
    (out_data_o.stream_id != '0))
    else $error("new entry with zero id");

endmodule

bind stream_id_table_with_idle_eviction sit_checker u_sit_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

FILE: bench/stream_id_table_with_idle_eviction_test.sv
// Self-checking bench for the stream id table: random headers, phased settings, slot predictor.
`timescale 1ns / 1ps

module stream_id_table_with_idle_eviction_test;
  import sit_pkg::*;

  // Index past the last register, for a write that must be ignored
  localparam logic [1:0] REG_SPARE = 2'd3;

  localparam int PHASES         = 8;
  localparam int PHASE_BEATS    = 142;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 2000;

  // Predicts each table result and holds the results still owed by the block
  class stream_table_scoreboard;
    logic [PT_W-1:0]   screen_pt;
    logic [PT_W-1:0]   camera_pt;
    logic [TO_W-1:0]   idle_timeout;
    bit                slot_used[TABLE_SLOTS];
    logic [ID_W-1:0]   slot_key[TABLE_SLOTS];
    logic [TIME_W-1:0] slot_seen[TABLE_SLOTS];
    out_item_t         owed_results[$];
    int unsigned       errors;

    function new();
      screen_pt    = '0;
      camera_pt    = '0;
      idle_timeout = TIMEOUT_RESET;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      errors = 0;
    endfunction

    function void set_register(logic [1:0] index, logic [PDATA_W-1:0] value);
      case (index)
        REG_SCREEN:  screen_pt = value[PT_W-1:0];
        REG_CAMERA:  camera_pt = value[PT_W-1:0];
        REG_TIMEOUT: idle_timeout = value[TO_W-1:0];
        default: ;
      endcase
    endfunction

    // Work out the result of one accepted header and update the table copy
    function void note_packet(in_item_t h);
      out_item_t        res;
      logic [ID_W-1:0]  id;
      bit               pinned;
      bit               drop;
      int               hit_slot;
      int               free_slot;
      int               oldest;
      int               live;
      int unsigned      dropped;
      res       = '0;
      hit_slot  = -1;
      free_slot = -1;
      live      = 0;
      dropped   = 0;
      pinned    = (h.pinned_source != '0);
      if ((h.payload_type == screen_pt || h.payload_type == camera_pt) &&
          (!pinned || h.packet_source == h.pinned_source)) begin
        id = pinned ? h.pinned_source : h.packet_source;
        if (id == '0) begin
          res.status = ST_NO_STREAM;
        end else begin
          foreach (slot_used[i])
            if (hit_slot < 0 && slot_used[i] && slot_key[i] == id) hit_slot = i;
          if (hit_slot >= 0) begin
            slot_seen[hit_slot] = h.now_ms;
            res.status    = ST_HIT;
            res.stream_id = id;
            res.slot      = 3'(hit_slot);
          end else begin
            // Prune: pinned mode clears other streams, else drop idle ones
            foreach (slot_used[i]) begin
              if (slot_used[i]) begin
                if (pinned)
                  drop = (slot_key[i] != h.pinned_source);
                else
                  drop = (h.now_ms >= slot_seen[i]) &&
                         ((h.now_ms - slot_seen[i]) > TIME_W'(idle_timeout));
                if (drop) begin
                  slot_used[i] = 1'b0;
                  dropped++;
                end else begin
                  live++;
                end
              end
            end
            // Evict the oldest while full; lowest slot wins ties
            while (live >= TABLE_SLOTS) begin
              oldest = -1;
              foreach (slot_used[i])
                if (slot_used[i] && (oldest < 0 || slot_seen[i] < slot_seen[oldest]))
                  oldest = i;
              slot_used[oldest] = 1'b0;
              dropped++;
              live--;
            end
            foreach (slot_used[i])
              if (free_slot < 0 && !slot_used[i]) free_slot = i;
            slot_used[free_slot] = 1'b1;
            slot_key[free_slot]  = id;
            slot_seen[free_slot] = h.now_ms;
            res.status        = ST_NEW;
            res.stream_id     = id;
            res.slot          = 3'(free_slot);
            res.removed_count = (dropped > 15) ? 4'hF : 4'(dropped);
          end
        end
      end
      owed_results.insert(owed_results.size(), res);
    endfunction

    function void flag(string field, logic [ID_W-1:0] want, logic [ID_W-1:0] got);
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      errors++;
    endfunction

    // Compare one accepted result beat with the oldest owed result
    function void check_result(out_item_t got);
      out_item_t want;
      if (owed_results.size() == 0) begin
        $display("%0t: result beat with none owed, expected nothing, actual %h", $time, got);
        errors++;
        return;
      end
      want = owed_results[0];
      owed_results.delete(0);
      if (got.status !== want.status)
        flag("status", ID_W'(want.status), ID_W'(got.status));
      if (got.stream_id !== want.stream_id) flag("stream_id", want.stream_id, got.stream_id);
      if (got.slot !== want.slot) flag("slot", ID_W'(want.slot), ID_W'(got.slot));
      if (got.removed_count !== want.removed_count)
        flag("removed_count", ID_W'(want.removed_count), ID_W'(got.removed_count));
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni    = 1'b0;
  logic                pkt_valid = 1'b0;
  logic                pkt_stall;
  in_item_t            pkt_beat  = '0;
  logic                res_valid;
  logic                res_stall = 1'b0;
  out_item_t           res_beat;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [PADDR_W-1:0]  paddr     = '0;
  logic [PDATA_W-1:0]  pwdata    = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  stream_table_scoreboard sb;

  // Sender pacing, packet clock and the stream ids of the current phase
  int                 burst_left = 0;
  logic [TIME_W-1:0]  now_clock  = '0;
  logic [ID_W-1:0]    id_pool[16];
  int                 pool_n;

  // Receiver stall pattern
  int                 stall_mode = 0;
  int                 mode_left  = 0;
  int                 stall_run  = 0;
  int unsigned        cycle_cnt  = 0;
  bit                 hold_res;
  int                 quiet_cycles = 0;

  stream_id_table_with_idle_eviction u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pkt_valid),
    .in_stall_o  (pkt_stall),
    .in_data_i   (pkt_beat),
    .out_valid_o (res_valid),
    .out_stall_i (res_stall),
    .out_data_o  (res_beat),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Write one register: setup cycle, then access cycle until pready
  task automatic apb_write(input logic [1:0] index, input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({index, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.set_register(index, value);
  endtask

  // Offer one header beat, with a random gap ahead when the burst is spent
  task automatic send_header(input in_item_t h);
    if (burst_left == 0) begin
      pkt_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
    end
    burst_left--;
    pkt_valid <= 1'b1;
    pkt_beat  <= h;
    @(posedge clk_i);
    while (pkt_stall) @(posedge clk_i);
    sb.note_packet(h);
  endtask

  // Drop valid and wait until every owed result has come, then let the block settle
  task automatic drain_results();
    pkt_valid <= 1'b0;
    burst_left = 0;
    while (sb.owed_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic in_item_t header(logic [PT_W-1:0] pt, logic [ID_W-1:0] src,
                                      logic [ID_W-1:0] pin, logic [TIME_W-1:0] now);
    in_item_t h;
    h.payload_type  = pt;
    h.packet_source = src;
    h.pinned_source = pin;
    h.now_ms        = now;
    return h;
  endfunction

  // Program the accepted types and timeout for one phase, extremes first
  task automatic apply_phase_settings(input int phase);
    logic [PT_W-1:0] scr;
    logic [PT_W-1:0] cam;
    logic [TO_W-1:0] tmo;
    scr = 7'($urandom());
    cam = 7'($urandom());
    case (phase)
      0: begin scr = 7'd127; cam = 7'd0;  tmo = '0; end
      1: begin scr = 7'd96;  cam = 7'd97; tmo = 32'd50; end
      2: begin scr = 7'd0;   cam = 7'd127; tmo = 32'hFFFF_FFFF; end
      3: begin scr = 7'd35;  cam = 7'd35; tmo = 32'd1000; end
      4: tmo = $urandom_range(0, 100000);
      5: tmo = TIMEOUT_RESET;
      6: tmo = 32'd1;
      default: tmo = $urandom();
    endcase
    apb_write(REG_SCREEN, {25'($urandom()), scr});
    apb_write(REG_CAMERA, {25'($urandom()), cam});
    apb_write(REG_TIMEOUT, tmo);
    if (phase == 3) apb_write(REG_SPARE, $urandom());
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Mostly well-formed headers on a small id pool, with noise mixed in
  function automatic in_item_t next_header();
    in_item_t          h;
    logic [TIME_W-1:0] win;
    int unsigned       kind;
    logic [ID_W-1:0]   pick;
    kind = $urandom_range(0, 99);
    pick = id_pool[$urandom_range(0, pool_n - 1)];
    // advance the packet clock: small steps, idle-length steps, jumps, going back
    case ($urandom_range(0, 19))
      0: now_clock = TIME_W'({$urandom(), $urandom()});
      1: now_clock = now_clock - TIME_W'($urandom_range(0, 200));
      2, 3: begin
        win = (sb.idle_timeout > 100000) ? TIME_W'(100000) : TIME_W'(sb.idle_timeout);
        now_clock = now_clock + TIME_W'($urandom_range(0, 32'(2 * win + 2)));
      end
      default: now_clock = now_clock + TIME_W'($urandom_range(0, 30));
    endcase
    h.now_ms        = now_clock;
    h.payload_type  = $urandom_range(0, 1) ? sb.screen_pt : sb.camera_pt;
    h.packet_source = pick;
    h.pinned_source = '0;
    if (kind >= 87) begin
      h.payload_type  = 7'($urandom_range(0, 127));
      h.packet_source = $urandom();
      case ($urandom_range(0, 2))
        0: h.pinned_source = $urandom();
        1: h.pinned_source = h.packet_source;
        default: h.pinned_source = '0;
      endcase
    end else if (kind >= 81) begin
      h.packet_source = '0;
    end else if (kind >= 74) begin
      h.packet_source = $urandom();
    end else if (kind >= 66) begin
      h.pinned_source = pick;
      if ($urandom_range(0, 9) == 0) h.packet_source = $urandom();
    end
    return h;
  endfunction

  // Take result beats and drive the receiver's stall pattern
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_valid && !res_stall) sb.check_result(res_beat);
      cycle_cnt++;
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(64, 300);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: hold_res = 1'b0;
        1: hold_res = ($urandom_range(0, 4) == 0);
        2: hold_res = ($urandom_range(0, 2) != 0);
        default: hold_res = ((cycle_cnt % 7) < 3);
      endcase
      if (stall_run >= 12) hold_res = 1'b0;
      stall_run = hold_res ? stall_run + 1 : 0;
      res_stall <= hold_res;
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (pkt_valid && !pkt_stall) || (res_valid && !res_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("stream_id_table_with_idle_eviction_test: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings accept payload type zero only
    send_header(header(7'd1, 32'h5, '0, 48'd0));             // type matches neither
    send_header(header(7'd0, '0, '0, 48'd1));                 // id zero, no stream
    send_header(header(7'd0, 32'h7, 32'h9, 48'd2));           // source differs from pin
    send_header(header(7'd0, 32'hFFFF_FFFF, '0, 48'd1000));
    for (int k = 1; k < TABLE_SLOTS; k++)
      send_header(header(7'd0, 32'(k), '0, 48'd1000));        // fill, all seen at once
    send_header(header(7'd0, 32'h3, '0, 48'd2000));           // hit refreshes slot 3
    send_header(header(7'd0, 32'h8000_0000, '0, 48'd1500));   // full: tie, lowest slot goes
    send_header(header(7'd0, 32'h1234, '0, 48'hFFFF_FFFF_FFFF)); // everything idle
    send_header(header(7'd0, 32'h9, '0, 48'd0));              // clock went back, keep entry
    send_header(header(7'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'd5)); // pinned miss clears rest
    send_header(header(7'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'd6)); // pinned hit
    send_header(header(7'd127, 32'hFFFF_FFFF, '0, 48'd7));    // top type, not accepted

    for (int phase = 0; phase < PHASES; phase++) begin
      drain_results();
      apply_phase_settings(phase);
      pool_n = $urandom_range(9, 14);
      for (int k = 0; k < pool_n; k++) begin
        id_pool[k] = $urandom();
        if (id_pool[k] == '0) id_pool[k] = 32'hFFFF_FFFF;
      end
      repeat (PHASE_BEATS) send_header(next_header());
    end

    drain_results();
    if (sb.errors == 0)
      $display("stream_id_table_with_idle_eviction_test: PASS");
    else
      $display("stream_id_table_with_idle_eviction_test: FAIL");
    $finish;
  end

endmodule
